@@ hw/rtl/bsc_pkg.sv @@
package bsc_pkg;

    // Counter and converter widths.
    localparam int COUNT_BITS = 32;
    localparam int ADC_BITS = 12;

    // Fixed field widths.
    localparam int HALF_BITS = 31;
    localparam int CMP_BITS = 33;
    localparam int PHASE_BITS = 12;
    localparam int THROTTLE_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 31;
    localparam int LAST_STEP = 5;

    // Register reset values.
    localparam logic [15:0] START_THROTTLE_RST = 16'd50;
    localparam logic [15:0] START_DELAY_RST = 16'd5;
    localparam logic [3:0] BLANK_COUNT_RST = 4'd2;
    localparam logic [HALF_BITS-1:0] FAST_LIMIT_RST = 31'd12000;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_SUPERVISE = 2'd2
    } action_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_REVERSE_DIR = 3'd0,
        CFG_START_THROTTLE = 3'd1,
        CFG_START_DELAY = 3'd2,
        CFG_BLANK_COUNT = 3'd3,
        CFG_FAST_LIMIT = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } phase_sel_t;

    typedef struct packed {
        logic [1:0] action;
        logic [PHASE_BITS-1:0] phase_a;
        logic [PHASE_BITS-1:0] phase_b;
        logic [PHASE_BITS-1:0] phase_c;
        logic [PHASE_BITS-1:0] neutral_level;
        logic [THROTTLE_BITS-1:0] throttle;
    } item_t;

    typedef struct packed {
        logic [5:0] gates;
        logic [2:0] step;
        logic running;
        logic commutated;
        logic zero_cross;
        logic [HALF_BITS-1:0] half_interval;
        logic slow_start;
    } result_t;

    // Gate pattern for a step, forward or reverse rotation.
    function automatic logic [5:0] gate_lookup(input logic rev, input logic [2:0] pos);
        logic [5:0] g;
        case (pos)
            3'd0: g = rev ? 6'h0A : 6'h11;
            3'd1: g = rev ? 6'h0C : 6'h14;
            3'd2: g = rev ? 6'h14 : 6'h0C;
            3'd3: g = rev ? 6'h11 : 6'h0A;
            3'd4: g = rev ? 6'h21 : 6'h22;
            3'd5: g = rev ? 6'h22 : 6'h21;
            default: g = 6'h00;
        endcase
        return g;
    endfunction

    // Floating phase watched during a step.
    function automatic phase_sel_t sense_phase(input logic rev, input logic [2:0] pos);
        phase_sel_t s;
        case (pos)
            3'd1: s = rev ? PH_B : PH_A;
            3'd2: s = rev ? PH_A : PH_B;
            3'd4: s = rev ? PH_B : PH_A;
            3'd5: s = rev ? PH_A : PH_B;
            default: s = PH_C;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/bsc_if.sv @@
// Input item channel.
interface bsc_item_if;
    logic valid;
    logic ready;
    bsc_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result item channel.
interface bsc_result_if;
    logic valid;
    logic ready;
    bsc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Register write channel.
interface bsc_cfg_if;
    logic valid;
    logic ready;
    logic [bsc_pkg::CFG_INDEX_BITS-1:0] index;
    logic [bsc_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/bldc_sensorless_commutator.sv @@
// Six-step sensorless BLDC commutation controller.
//
// Channels: item carries one action (tick, PWM phase sample or supervisor
// check) with the phase samples, neutral level and throttle; result returns
// exactly one item per input transfer with gates, step, run state, event
// flags, the last half interval and the slow start flag. cfg writes one of
// five registers by index; it is always ready and should only be used while
// the block is idle.
//
// An input transfer passes through the input register, then the state update
// and result register, before its result can be taken. Throughput is one item
// per cycle while the result receiver does not stall; the tick counter, compare
// and state update all fit in the single pass between those registers.
//
// Reset clears both pipeline registers, loads the default register values
// and puts the motor in the stopped state with all switches off. When the
// result receiver stalls, the result register holds and the input register
// fills; item.ready then drops until the result is taken.
module bldc_sensorless_commutator (
    input logic clk,
    input logic rst_n,
    bsc_item_if.sink item,
    bsc_result_if.source result,
    bsc_cfg_if.sink cfg
);

    // Configuration registers.
    logic reverse_dir_reg;
    logic [15:0] start_throttle_reg;
    logic [15:0] start_delay_reg;
    logic [3:0] blank_count_reg;
    logic [bsc_pkg::HALF_BITS-1:0] fast_limit_reg;

    // Controller state.
    logic [2:0] position_reg, position_next;
    logic run_reg, run_next;
    logic [bsc_pkg::COUNT_BITS-1:0] tick_reg, tick_next;
    logic [bsc_pkg::HALF_BITS-1:0] compare_reg, compare_next;
    logic [3:0] blank_left_reg, blank_left_next;
    logic armed_reg, armed_next;
    logic slow_reg, slow_next;
    logic [5:0] gate_reg, gate_next;
    logic [bsc_pkg::HALF_BITS-1:0] last_half_reg, last_half_next;

    // Pipeline registers.
    bsc_pkg::item_t item_reg;
    logic item_valid_reg;
    bsc_pkg::result_t result_reg;
    logic result_valid_reg;

    logic advance;
    logic did_comm, did_zc;
    logic [bsc_pkg::COUNT_BITS-1:0] tick_inc;
    logic [2:0] pos_adv;
    logic [2:0] sense_pos;
    bsc_pkg::phase_sel_t sel;
    logic [bsc_pkg::ADC_BITS-1:0] level, sensed;
    logic hit;
    logic all_zero;
    logic run_after_stop;
    logic [bsc_pkg::HALF_BITS-1:0] half;

    // The input stage moves on whenever the result register is free or drained.
    assign advance = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign result.valid = result_valid_reg;
    assign result.data = result_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_dir_reg <= 1'b0;
            start_throttle_reg <= bsc_pkg::START_THROTTLE_RST;
            start_delay_reg <= bsc_pkg::START_DELAY_RST;
            blank_count_reg <= bsc_pkg::BLANK_COUNT_RST;
            fast_limit_reg <= bsc_pkg::FAST_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bsc_pkg::CFG_REVERSE_DIR: reverse_dir_reg <= cfg.data[0];
                bsc_pkg::CFG_START_THROTTLE: start_throttle_reg <= cfg.data[15:0];
                bsc_pkg::CFG_START_DELAY: start_delay_reg <= cfg.data[15:0];
                bsc_pkg::CFG_BLANK_COUNT: blank_count_reg <= cfg.data[3:0];
                bsc_pkg::CFG_FAST_LIMIT: fast_limit_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.data;
        end
    end

    // Shared helper values for the actions.
    always_comb
    begin
        tick_inc = tick_reg + 1'b1;
        pos_adv = (position_reg >= 3'(bsc_pkg::LAST_STEP)) ? 3'd0 : position_reg + 3'd1;
        sense_pos = (position_reg <= 3'(bsc_pkg::LAST_STEP)) ? position_reg : 3'd0;
        sel = bsc_pkg::sense_phase(reverse_dir_reg, sense_pos);
        level = bsc_pkg::ADC_BITS'(item_reg.neutral_level);
        case (sel)
            bsc_pkg::PH_A: sensed = bsc_pkg::ADC_BITS'(item_reg.phase_a);
            bsc_pkg::PH_B: sensed = bsc_pkg::ADC_BITS'(item_reg.phase_b);
            default: sensed = bsc_pkg::ADC_BITS'(item_reg.phase_c);
        endcase
        hit = sense_pos[0] ? (level > sensed) : (sensed > level);
        half = bsc_pkg::HALF_BITS'(tick_reg >> 1);
        all_zero = (bsc_pkg::ADC_BITS'(item_reg.phase_a) == '0)
                && (bsc_pkg::ADC_BITS'(item_reg.phase_b) == '0)
                && (bsc_pkg::ADC_BITS'(item_reg.phase_c) == '0);
        run_after_stop = run_reg && !all_zero;
    end

    // Next state for the item in the input register.
    always_comb
    begin
        position_next = position_reg;
        run_next = run_reg;
        tick_next = tick_reg;
        compare_next = compare_reg;
        blank_left_next = blank_left_reg;
        armed_next = armed_reg;
        slow_next = slow_reg;
        gate_next = gate_reg;
        last_half_next = last_half_reg;
        did_comm = 1'b0;
        did_zc = 1'b0;
        case (item_reg.action)
            bsc_pkg::ACT_TICK:
            begin
                if (!(&tick_reg))
                begin
                    tick_next = tick_inc;
                    if (run_reg && (bsc_pkg::CMP_BITS'(tick_inc)
                                    == bsc_pkg::CMP_BITS'(compare_reg)))
                    begin
                        position_next = pos_adv;
                        gate_next = bsc_pkg::gate_lookup(reverse_dir_reg, pos_adv);
                        blank_left_next = blank_count_reg;
                        armed_next = 1'b1;
                        did_comm = 1'b1;
                    end
                end
            end
            bsc_pkg::ACT_SAMPLE:
            begin
                if (blank_left_reg != 4'd0)
                begin
                    blank_left_next = blank_left_reg - 4'd1;
                end
                else if (armed_reg && hit)
                begin
                    did_zc = 1'b1;
                    armed_next = 1'b0;
                    last_half_next = half;
                    compare_next = half;
                    tick_next = '0;
                    if (half < fast_limit_reg)
                    begin
                        slow_next = 1'b0;
                    end
                end
            end
            bsc_pkg::ACT_SUPERVISE:
            begin
                // Stop test first, then the start test on the updated run state.
                if (all_zero)
                begin
                    run_next = 1'b0;
                    armed_next = 1'b0;
                    gate_next = 6'h00;
                end
                if (!run_after_stop && (item_reg.throttle > start_throttle_reg))
                begin
                    tick_next = '0;
                    compare_next = bsc_pkg::HALF_BITS'(start_delay_reg);
                    run_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // State update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= 3'd0;
            run_reg <= 1'b0;
            tick_reg <= '0;
            compare_reg <= '0;
            blank_left_reg <= 4'd1;
            armed_reg <= 1'b0;
            slow_reg <= 1'b1;
            gate_reg <= 6'h00;
            last_half_reg <= '0;
        end
        else if (advance)
        begin
            position_reg <= position_next;
            run_reg <= run_next;
            tick_reg <= tick_next;
            compare_reg <= compare_next;
            blank_left_reg <= blank_left_next;
            armed_reg <= armed_next;
            slow_reg <= slow_next;
            gate_reg <= gate_next;
            last_half_reg <= last_half_next;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.gates <= gate_next;
            result_reg.step <= position_next;
            result_reg.running <= run_next;
            result_reg.commutated <= did_comm;
            result_reg.zero_cross <= did_zc;
            result_reg.half_interval <= last_half_next;
            result_reg.slow_start <= slow_next;
        end
    end

endmodule

@@ hw/rtl/bsc_checker.sv @@
module bsc_checker (
    input logic clk,
    input logic rst_n,
    input logic result_valid,
    input logic result_ready,
    input logic [5:0] gates,
    input logic [2:0] step,
    input logic running,
    input logic commutated,
    input logic zero_cross
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // A commutation only happens in run state and drives exactly two switches.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && commutated |-> running && ($countones(gates) == 2))
        else $error("commutation outside run state or bad gate pattern");

    // A stopped motor has every switch off.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !running |-> gates == 6'h00)
        else $error("gates driven while stopped");

    // One item never both commutates and detects a crossing; step stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(commutated && zero_cross) && (step <= 3'd5))
        else $error("conflicting events or step out of range");

endmodule

bind bldc_sensorless_commutator bsc_checker u_bsc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .gates(result.data.gates),
    .step(result.data.step),
    .running(result.data.running),
    .commutated(result.data.commutated),
    .zero_cross(result.data.zero_cross)
);

@@ tb/sv/tb_bldc_sensorless_commutator.sv @@
module tb_bldc_sensorless_commutator;

    // Action code with no function in the block.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int WAIT_MAX = 18;
    localparam int HOLD_AFTER = 350;
    localparam int HOLD_CYCLES = 120;
    localparam int PRINT_LIMIT = 100;
    localparam int NUM_SETS = 6;
    localparam logic [bsc_pkg::PHASE_BITS-1:0] ADC_MAX = '1;
    localparam logic [bsc_pkg::THROTTLE_BITS-1:0] THR_MAX = '1;

    // Commutation tables, steps 0 to 5.
    localparam logic [5:0] FWD_GATES [6] = '{6'h11, 6'h14, 6'h0C, 6'h0A, 6'h22, 6'h21};
    localparam logic [5:0] REV_GATES [6] = '{6'h0A, 6'h0C, 6'h14, 6'h11, 6'h21, 6'h22};
    localparam bsc_pkg::phase_sel_t FWD_SENSE [6] = '{bsc_pkg::PH_C, bsc_pkg::PH_A,
        bsc_pkg::PH_B, bsc_pkg::PH_C, bsc_pkg::PH_A, bsc_pkg::PH_B};
    localparam bsc_pkg::phase_sel_t REV_SENSE [6] = '{bsc_pkg::PH_C, bsc_pkg::PH_B,
        bsc_pkg::PH_A, bsc_pkg::PH_C, bsc_pkg::PH_B, bsc_pkg::PH_A};

    typedef struct {
        bsc_pkg::item_t stim;
        bit typed;
        bsc_pkg::result_t want;
    } plan_row_t;

    typedef struct {
        logic reverse;
        logic [15:0] start_thr;
        logic [15:0] start_dly;
        logic [3:0] blank;
        logic [bsc_pkg::HALF_BITS-1:0] fast;
        int items;
    } motor_setting_t;

    logic clk = 1'b0;
    logic rst_n;

    bsc_item_if item_ch ();
    bsc_result_if res_ch ();
    bsc_cfg_if cfg_ch ();

    // Register copies held by the predictor.
    logic r_reverse = 1'b0;
    logic [15:0] r_start_thr = bsc_pkg::START_THROTTLE_RST;
    logic [15:0] r_start_dly = bsc_pkg::START_DELAY_RST;
    logic [3:0] r_blank_cnt = bsc_pkg::BLANK_COUNT_RST;
    logic [bsc_pkg::HALF_BITS-1:0] r_fast_limit = bsc_pkg::FAST_LIMIT_RST;

    // Motor state held by the predictor.
    logic [2:0] m_pos = '0;
    logic m_running = 1'b0;
    logic [bsc_pkg::COUNT_BITS-1:0] m_ticks = '0;
    logic [bsc_pkg::COUNT_BITS-1:0] m_cmp = '0;
    logic [3:0] m_blank = 4'd1;
    logic m_armed = 1'b0;
    logic m_slow = 1'b1;
    logic [5:0] m_gates = '0;
    logic [bsc_pkg::HALF_BITS-1:0] m_half = '0;

    bsc_pkg::result_t motor_results [$];
    plan_row_t plan [$];
    int errors = 0;
    int results_taken = 0;
    bit holding = 1'b0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    bldc_sensorless_commutator u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(res_ch),
        .cfg(cfg_ch)
    );

    // Clock with a period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard limit on the length of the run.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Advance the motor state by one item and return the result it produces.
    function automatic bsc_pkg::result_t motor_step(input bsc_pkg::item_t stim);
        bsc_pkg::result_t r;
        logic comm;
        logic zc;
        logic hit;
        logic [2:0] p;
        bsc_pkg::phase_sel_t sel;
        logic [bsc_pkg::PHASE_BITS-1:0] seen;
        comm = 1'b0;
        zc = 1'b0;
        case (stim.action)
            bsc_pkg::ACT_TICK:
            begin
                if (m_ticks != '1)
                begin
                    m_ticks = m_ticks + 1'b1;
                    if (m_running && m_ticks == m_cmp)
                    begin
                        m_pos = (m_pos >= bsc_pkg::LAST_STEP) ? 3'd0 : m_pos + 3'd1;
                        m_gates = r_reverse ? REV_GATES[m_pos] : FWD_GATES[m_pos];
                        m_blank = r_blank_cnt;
                        m_armed = 1'b1;
                        comm = 1'b1;
                    end
                end
            end
            bsc_pkg::ACT_SAMPLE:
            begin
                if (m_blank != 0)
                begin
                    m_blank = m_blank - 4'd1;
                end
                else if (m_armed)
                begin
                    p = (m_pos <= bsc_pkg::LAST_STEP) ? m_pos : 3'd0;
                    sel = r_reverse ? REV_SENSE[p] : FWD_SENSE[p];
                    seen = (sel == bsc_pkg::PH_A) ? stim.phase_a :
                           (sel == bsc_pkg::PH_B) ? stim.phase_b : stim.phase_c;
                    // Odd steps watch a falling phase, even steps a rising one.
                    hit = p[0] ? (stim.neutral_level > seen) : (seen > stim.neutral_level);
                    if (hit)
                    begin
                        zc = 1'b1;
                        m_armed = 1'b0;
                        m_half = bsc_pkg::HALF_BITS'(m_ticks >> 1);
                        m_cmp = bsc_pkg::COUNT_BITS'(m_half);
                        m_ticks = '0;
                        if (m_half < r_fast_limit)
                            m_slow = 1'b0;
                    end
                end
            end
            bsc_pkg::ACT_SUPERVISE:
            begin
                if (stim.phase_a == 0 && stim.phase_b == 0 && stim.phase_c == 0)
                begin
                    m_running = 1'b0;
                    m_armed = 1'b0;
                    m_gates = '0;
                end
                if (!m_running && stim.throttle > r_start_thr)
                begin
                    m_ticks = '0;
                    m_cmp = bsc_pkg::COUNT_BITS'(r_start_dly);
                    m_running = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.gates = m_gates;
        r.step = m_pos;
        r.running = m_running;
        r.commutated = comm;
        r.zero_cross = zc;
        r.half_interval = m_half;
        r.slow_start = m_slow;
        return r;
    endfunction

    function automatic bsc_pkg::item_t make_item(input logic [1:0] act, input logic [11:0] a,
                                                 input logic [11:0] b, input logic [11:0] c,
                                                 input logic [11:0] lvl,
                                                 input logic [15:0] thr);
        bsc_pkg::item_t it;
        it.action = act;
        it.phase_a = a;
        it.phase_b = b;
        it.phase_c = c;
        it.neutral_level = lvl;
        it.throttle = thr;
        return it;
    endfunction

    function automatic bsc_pkg::result_t make_result(input logic [5:0] gates,
                                                     input logic [2:0] step,
                                                     input logic running, input logic comm,
                                                     input logic zc,
                                                     input logic [bsc_pkg::HALF_BITS-1:0] half,
                                                     input logic slow);
        bsc_pkg::result_t r;
        r.gates = gates;
        r.step = step;
        r.running = running;
        r.commutated = comm;
        r.zero_cross = zc;
        r.half_interval = half;
        r.slow_start = slow;
        return r;
    endfunction

    function automatic void add_row(input bsc_pkg::item_t stim, input bit typed,
                                    input bsc_pkg::result_t want);
        plan_row_t row;
        row.stim = stim;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    // Wait in cycles before the next transfer; runs of zero come and go.
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, WAIT_MAX);
    endfunction

    // Random item, mostly ticks and samples aimed at the phase the motor watches.
    function automatic bsc_pkg::item_t draw_item();
        bsc_pkg::item_t it;
        int pick;
        logic [2:0] p;
        bsc_pkg::phase_sel_t sel;
        logic [bsc_pkg::PHASE_BITS-1:0] lvl;
        logic [bsc_pkg::PHASE_BITS-1:0] seen;
        bit hit;
        it = make_item(bsc_pkg::ACT_TICK, 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            it.action = bsc_pkg::ACT_TICK;
        end
        else if (pick < 85)
        begin
            it.action = bsc_pkg::ACT_SAMPLE;
            if ($urandom_range(0, 9) < 7)
            begin
                p = (m_pos <= bsc_pkg::LAST_STEP) ? m_pos : 3'd0;
                sel = r_reverse ? REV_SENSE[p] : FWD_SENSE[p];
                // Let the interval grow before the crossing shows up.
                hit = (m_ticks >= $urandom_range(2, 30));
                if (!p[0] == hit)
                begin
                    lvl = 12'($urandom_range(0, 4094));
                    seen = 12'($urandom_range(lvl + 1, 4095));
                end
                else
                begin
                    lvl = 12'($urandom_range(1, 4095));
                    seen = 12'($urandom_range(0, lvl - 1));
                end
                it.neutral_level = lvl;
                case (sel)
                    bsc_pkg::PH_A: it.phase_a = seen;
                    bsc_pkg::PH_B: it.phase_b = seen;
                    default: it.phase_c = seen;
                endcase
            end
        end
        else if (pick < 95)
        begin
            it.action = bsc_pkg::ACT_SUPERVISE;
            if ($urandom_range(0, 9) < 4)
            begin
                it.phase_a = '0;
                it.phase_b = '0;
                it.phase_c = '0;
            end
            if ($urandom_range(0, 1) == 0)
                it.throttle = (r_start_thr == THR_MAX) ? r_start_thr :
                              r_start_thr + 16'($urandom_range(0, 1));
        end
        else
        begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                     what, got, want, results_taken);
        errors++;
    endtask

    // Present one item, wait for its transfer and queue what it should produce.
    task automatic send_item(input bsc_pkg::item_t stim, input bit typed,
                             input bsc_pkg::result_t want);
        int gap;
        bsc_pkg::result_t calc;
        gap = holding ? 0 : draw_wait(tx_quiet);
        @(negedge clk);
        repeat (gap)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= stim;
        do
            @(posedge clk);
        while (!item_ch.ready);
        calc = motor_step(stim);
        motor_results.push_back(typed ? want : calc);
    endtask

    // Stop offering items and wait until every queued result has come back.
    task automatic drain(input int extra);
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (motor_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input bsc_pkg::cfg_index_t idx,
                             input logic [bsc_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            bsc_pkg::CFG_REVERSE_DIR: r_reverse = value[0];
            bsc_pkg::CFG_START_THROTTLE: r_start_thr = value[15:0];
            bsc_pkg::CFG_START_DELAY: r_start_dly = value[15:0];
            bsc_pkg::CFG_BLANK_COUNT: r_blank_cnt = value[3:0];
            bsc_pkg::CFG_FAST_LIMIT: r_fast_limit = value[bsc_pkg::HALF_BITS-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random stalls, one long hold, and the field comparison.
    initial
    begin
        int stall;
        bit hold_done;
        bsc_pkg::result_t got;
        bsc_pkg::result_t want;
        hold_done = 1'b0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                holding = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = draw_wait(rx_quiet);
            end
            repeat (stall)
            begin
                res_ch.ready <= 1'b0;
                @(negedge clk);
            end
            holding = 1'b0;
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got = res_ch.data;
            results_taken++;
            if (motor_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'(got.step), 32'd0);
            end
            else
            begin
                want = motor_results.pop_front();
                if (got.gates !== want.gates)
                    report_mismatch("gates", 32'(got.gates), 32'(want.gates));
                if (got.step !== want.step)
                    report_mismatch("step", 32'(got.step), 32'(want.step));
                if (got.running !== want.running)
                    report_mismatch("running", 32'(got.running), 32'(want.running));
                if (got.commutated !== want.commutated)
                    report_mismatch("commutated", 32'(got.commutated),
                                    32'(want.commutated));
                if (got.zero_cross !== want.zero_cross)
                    report_mismatch("zero_cross", 32'(got.zero_cross),
                                    32'(want.zero_cross));
                if (got.half_interval !== want.half_interval)
                    report_mismatch("half_interval", 32'(got.half_interval),
                                    32'(want.half_interval));
                if (got.slow_start !== want.slow_start)
                    report_mismatch("slow_start", 32'(got.slow_start),
                                    32'(want.slow_start));
            end
        end
    end

    // Stimulus: directed sequence, then random items under several settings.
    initial
    begin
        motor_setting_t sets [NUM_SETS];
        bsc_pkg::result_t idle_res;
        bsc_pkg::item_t stim;
        int n;

        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bsc_pkg::CFG_REVERSE_DIR;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: stopped motor, start, first steps, zero compare, restart.
        idle_res = make_result(6'h00, 3'd0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
        add_row(make_item(bsc_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b1, idle_res);
        add_row(make_item(ACT_UNUSED, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, THR_MAX),
                1'b1, idle_res);
        // Sample while blanking, with the motor stopped.
        add_row(make_item(bsc_pkg::ACT_SAMPLE, ADC_MAX, 0, ADC_MAX, 0, 0), 1'b1, idle_res);
        // Sample with detection not armed.
        add_row(make_item(bsc_pkg::ACT_SAMPLE, 0, ADC_MAX, ADC_MAX, 0, 0), 1'b1, idle_res);
        // Throttle equal to the start level does not start the motor.
        add_row(make_item(bsc_pkg::ACT_SUPERVISE, 1, 2, 3, 0, 50), 1'b1, idle_res);
        add_row(make_item(bsc_pkg::ACT_SUPERVISE, 100, 200, 300, 0, 51), 1'b1,
                make_result(6'h00, 3'd0, 1'b1, 1'b0, 1'b0, '0, 1'b1));
        // The fifth tick reaches the start delay and commutates.
        repeat (5)
            add_row(make_item(bsc_pkg::ACT_TICK, 12'h555, 12'hAAA, 12'h0F0, 12'h70F,
                              16'hA5A5), 1'b0, idle_res);
        repeat (2)
            add_row(make_item(bsc_pkg::ACT_SAMPLE, 0, 0, 0, ADC_MAX, 0), 1'b0, idle_res);
        // Step 1 watches phase A falling.
        add_row(make_item(bsc_pkg::ACT_SAMPLE, 0, 12'h800, 12'h800, ADC_MAX, 0), 1'b0,
                idle_res);
        repeat (2)
            add_row(make_item(bsc_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, idle_res);
        repeat (2)
            add_row(make_item(bsc_pkg::ACT_SAMPLE, 0, 0, 0, ADC_MAX, 0), 1'b0, idle_res);
        // Step 2 watches phase B rising.
        add_row(make_item(bsc_pkg::ACT_SAMPLE, 0, ADC_MAX, 0, 12'h400, 0), 1'b0, idle_res);
        add_row(make_item(bsc_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, idle_res);
        repeat (2)
            add_row(make_item(bsc_pkg::ACT_SAMPLE, 0, 0, 0, ADC_MAX, 0), 1'b0, idle_res);
        // Crossing at a count of one leaves a zero compare value.
        add_row(make_item(bsc_pkg::ACT_SAMPLE, ADC_MAX, ADC_MAX, 0, 12'h800, 0), 1'b0,
                idle_res);
        add_row(make_item(bsc_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, idle_res);
        // All phases at zero stop the motor and full throttle restarts it.
        add_row(make_item(bsc_pkg::ACT_SUPERVISE, 0, 0, 0, ADC_MAX, THR_MAX), 1'b0,
                idle_res);
        foreach (plan[i])
            send_item(plan[i].stim, plan[i].typed, plan[i].want);

        sets[0] = '{1'b1, 16'd0, 16'd1, 4'd0, 31'd0, 113};
        sets[1] = '{1'b0, 16'hFFFF, 16'hFFFF, 4'd15, 31'h7FFFFFFF, 60};
        sets[2] = '{1'b1, 16'd30, 16'd7, 4'd1, 31'd5, 113};
        sets[3] = '{1'b0, 16'($urandom_range(0, 200)), 16'($urandom_range(2, 25)),
                    4'($urandom_range(0, 4)), 31'($urandom_range(0, 20)), 113};
        sets[4] = '{1'b1, 16'd100, 16'd3, 4'd3, 31'h7FFFFFFF, 113};
        sets[5] = '{1'b0, 16'd50, 16'd12, 4'd2, 31'd12000, 113};

        // Random part, one block of items per register setting.
        foreach (sets[s])
        begin
            drain(4);
            write_reg(bsc_pkg::CFG_REVERSE_DIR,
                      bsc_pkg::CFG_DATA_BITS'(sets[s].reverse));
            write_reg(bsc_pkg::CFG_START_THROTTLE,
                      bsc_pkg::CFG_DATA_BITS'(sets[s].start_thr));
            write_reg(bsc_pkg::CFG_START_DELAY,
                      bsc_pkg::CFG_DATA_BITS'(sets[s].start_dly));
            write_reg(bsc_pkg::CFG_BLANK_COUNT,
                      bsc_pkg::CFG_DATA_BITS'(sets[s].blank));
            write_reg(bsc_pkg::CFG_FAST_LIMIT,
                      bsc_pkg::CFG_DATA_BITS'(sets[s].fast));
            n = 0;
            while (n < sets[s].items)
            begin
                stim = draw_item();
                if (stim.action != ACT_UNUSED)
                    n++;
                send_item(stim, 1'b0, idle_res);
            end
        end

        drain(WAIT_MAX + 10);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
